[sv/osc_bundle_validator_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bundle validator.
// Concurrent checks are compiled in unless SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef OSC_BUNDLE_VALIDATOR_CORE_MACROS_SVH
`define OSC_BUNDLE_VALIDATOR_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge out of reset.
`define OBV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define OBV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define OBV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define OBV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/obv_pkg.sv]
// ----------------------------------------------------------------------------
// obv_pkg
// Types and constants shared by the bundle validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obv_pkg;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_PAD,
        PH_TAG,
        PH_LEN,
        PH_BODY,
        PH_DRAIN
    } phase_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_SIZE       = 2'd1;
    localparam logic [1:0] STATUS_NOT_BUNDLE = 2'd2;

    localparam int TAG_BYTES  = 8;
    localparam int LEN_BYTES  = 4;
    localparam int MIN_BUNDLE = 16;

    // "#bundle" with its terminating zero.
    localparam logic [7:0] BUNDLE_TAG [8] = '{
        8'h23, 8'h62, 8'h75, 8'h6E, 8'h64, 8'h6C, 8'h65, 8'h00
    };

endpackage

`default_nettype wire

[sv/osc_bundle_validator_core.sv]
// ----------------------------------------------------------------------------
// osc_bundle_validator_core
// Checks a received bundle buffer, one byte per beat, and reports the verdict
// on the final byte.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, data_byte, last_byte  | sink
//  out     | out_valid, out_ready, status, total_length| source
//
//  One byte is taken per cycle while no final byte is held; each byte passes
//  an input register and the header/element tracking logic and, for the
//  final byte, the result register that holds its verdict.
//  Reset clears all tracking state; the block accepts data right away.
//  Only a final byte waits on a full result register, so stalls on the out
//  side hold the input only when a verdict cannot be written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osc_bundle_validator_core #(
    parameter int MAX_BYTES = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [16:0]      total_length
);

    import obv_pkg::*;

    `include "osc_bundle_validator_core_macros.svh"

    localparam int CW = $clog2(MAX_BYTES + 1);

    // Input register.
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_data_reg;
    logic        s1_last_reg;
    logic        s1_consume;

    // Tracking state.
    phase_t      phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next, cnt_upd;
    logic        match_reg, match_next;
    logic [3:0]  fld_reg, fld_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] left_reg, left_next;
    logic [1:0]  err_reg, err_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg;
    logic [16:0] total_reg;
    logic        res_load;
    logic [1:0]  res_status;
    logic [16:0] res_total;
    logic [CW+16:0] cnt_wide;

    // Values after this byte, before the end-of-buffer return to reset.
    phase_t      ph_upd;
    logic        match_upd;
    logic [3:0]  fld_upd;
    logic [31:0] shift_upd;
    logic [31:0] left_upd;
    logic [1:0]  err_upd;
    logic        overflow;

    // A non-final byte always proceeds; a final byte needs room for its verdict.
    assign s1_consume = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_consume;
    assign res_load   = s1_consume && s1_last_reg;
    assign overflow   = (cnt_reg >= CW'(MAX_BYTES));

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_consume)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        ph_upd    = phase_reg;
        cnt_upd   = cnt_reg;
        match_upd = match_reg;
        fld_upd   = fld_reg;
        shift_upd = shift_reg;
        left_upd  = left_reg;
        err_upd   = err_reg;

        if (overflow)
        begin
            err_upd = STATUS_SIZE;
            ph_upd  = PH_DRAIN;
        end
        else
        begin
            cnt_upd = cnt_reg + CW'(1);
            unique case (phase_reg)
                PH_HDR:
                begin
                    if (cnt_reg >= CW'(TAG_BYTES) || s1_data_reg != BUNDLE_TAG[cnt_reg[2:0]])
                    begin
                        match_upd = 1'b0;
                    end
                    if (s1_data_reg == 8'h00)
                    begin
                        // Bytes left to the next 4-byte boundary.
                        if (cnt_reg[1:0] == 2'b11)
                        begin
                            if (!match_upd)
                            begin
                                err_upd = STATUS_NOT_BUNDLE;
                                ph_upd  = PH_DRAIN;
                            end
                            else
                            begin
                                ph_upd  = PH_TAG;
                                fld_upd = 4'(TAG_BYTES);
                            end
                        end
                        else
                        begin
                            ph_upd  = PH_PAD;
                            fld_upd = {2'b00, ~cnt_reg[1:0]};
                        end
                    end
                end
                PH_PAD:
                begin
                    fld_upd = fld_reg - 4'd1;
                    if (s1_data_reg != 8'h00)
                    begin
                        err_upd = STATUS_SIZE;
                        ph_upd  = PH_DRAIN;
                    end
                    else if (fld_reg == 4'd1)
                    begin
                        if (!match_reg)
                        begin
                            err_upd = STATUS_NOT_BUNDLE;
                            ph_upd  = PH_DRAIN;
                        end
                        else
                        begin
                            ph_upd  = PH_TAG;
                            fld_upd = 4'(TAG_BYTES);
                        end
                    end
                end
                PH_TAG:
                begin
                    fld_upd = fld_reg - 4'd1;
                    if (fld_reg == 4'd1)
                    begin
                        ph_upd    = PH_LEN;
                        fld_upd   = 4'(LEN_BYTES);
                        shift_upd = 32'd0;
                    end
                end
                PH_LEN:
                begin
                    shift_upd = {shift_reg[23:0], s1_data_reg};
                    fld_upd   = fld_reg - 4'd1;
                    if (fld_reg == 4'd1)
                    begin
                        left_upd = shift_upd;
                        if (shift_upd == 32'd0)
                        begin
                            // An empty element: the next length starts at once.
                            fld_upd   = 4'(LEN_BYTES);
                            shift_upd = 32'd0;
                        end
                        else
                        begin
                            ph_upd = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    left_upd = left_reg - 32'd1;
                    if (left_reg == 32'd1)
                    begin
                        ph_upd    = PH_LEN;
                        fld_upd   = 4'(LEN_BYTES);
                        shift_upd = 32'd0;
                    end
                end
                PH_DRAIN:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Verdict for a final byte, taken from the updated state.
    always_comb
    begin
        cnt_wide   = {17'd0, cnt_upd};
        res_total  = 17'd0;
        if (err_upd != STATUS_OK)
        begin
            res_status = err_upd;
        end
        else if (ph_upd == PH_LEN && fld_upd == 4'(LEN_BYTES))
        begin
            res_status = STATUS_OK;
            res_total  = cnt_wide[16:0];
        end
        else
        begin
            res_status = STATUS_SIZE;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        match_next = match_reg;
        fld_next   = fld_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        err_next   = err_reg;
        if (s1_consume)
        begin
            if (s1_last_reg)
            begin
                phase_next = PH_HDR;
                cnt_next   = '0;
                match_next = 1'b1;
                fld_next   = 4'd0;
                shift_next = 32'd0;
                left_next  = 32'd0;
                err_next   = STATUS_OK;
            end
            else
            begin
                phase_next = ph_upd;
                cnt_next   = cnt_upd;
                match_next = match_upd;
                fld_next   = fld_upd;
                shift_next = shift_upd;
                left_next  = left_upd;
                err_next   = err_upd;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HDR;
            cnt_reg       <= '0;
            match_reg     <= 1'b1;
            fld_reg       <= 4'd0;
            shift_reg     <= 32'd0;
            left_reg      <= 32'd0;
            err_reg       <= STATUS_OK;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            match_reg     <= match_next;
            fld_reg       <= fld_next;
            shift_reg     <= shift_next;
            left_reg      <= left_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (res_load)
        begin
            status_reg <= res_status;
            total_reg  <= res_total;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign total_length = total_reg;

    // A valid bundle holds at least the padded header string and the time tag.
    `OBV_ASSERT_NOW(a_ok_min_len, clk, rst_n, res_load && res_status == STATUS_OK, cnt_upd >= CW'(MIN_BUNDLE), "valid verdict on a buffer shorter than a bundle header")

    `OBV_ASSERT_NOW(a_err_zero_len, clk, rst_n, out_valid_reg && status_reg != STATUS_OK, total_reg == 17'd0, "error verdict carries a nonzero length")

    `OBV_ASSERT_NEXT(a_end_resets, clk, rst_n, res_load, phase_reg == PH_HDR && cnt_reg == '0 && match_reg && err_reg == STATUS_OK, "tracking state not cleared after the final byte")

    `OBV_ASSERT_NEXT(a_hold_input, clk, rst_n, s1_valid_reg && !s1_consume, s1_valid_reg && $stable(s1_data_reg) && $stable(s1_last_reg), "held input beat lost or changed")

endmodule

`default_nettype wire

[tb/osc_bundle_validator_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osc_bundle_validator_checker
// Watches both channels of the bundle validator, tracks every accepted byte
// with its own copy of the header, time tag and element state, and compares
// each verdict the block hands out with the oldest one it has worked out.
// ----------------------------------------------------------------------------

module osc_bundle_validator_checker #(
    parameter int MAX_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [16:0] total_length,
    output int          mismatches,
    output int          pending,
    output int          verdicts,
    output int          beats
);

    import obv_pkg::*;

    localparam int PAD_ALIGN = 4;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] total_length;
    } verdict_t;

    verdict_t    verdict_q[$];
    verdict_t    want;

    phase_t      cur_phase;
    int unsigned seen_bytes;
    int unsigned field_end;
    int unsigned len_acc;
    int unsigned body_left;
    logic        hdr_ok;
    logic [1:0]  first_err;

    int          fail_cnt;
    int          verdicts_seen;
    int          beats_seen;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    task automatic clear_tracking();
        cur_phase  = PH_HDR;
        seen_bytes = 0;
        hdr_ok     = 1'b1;
        field_end  = 0;
        len_acc    = 0;
        body_left  = 0;
        first_err  = STATUS_OK;
    endtask

    task automatic open_length(input int unsigned nxt);
        cur_phase = PH_LEN;
        field_end = nxt + LEN_BYTES;
        len_acc   = 0;
    endtask

    // The string and its pad are complete; only now does a wrong string count.
    task automatic close_pad(input int unsigned nxt);
        if (!hdr_ok)
        begin
            first_err = STATUS_NOT_BUNDLE;
            cur_phase = PH_DRAIN;
        end
        else
        begin
            cur_phase = PH_TAG;
            field_end = nxt + TAG_BYTES;
        end
    endtask

    task automatic track_byte(input logic [7:0] b, input int unsigned pos);
        int unsigned nxt;
        nxt = pos + 1;
        case (cur_phase)
            PH_HDR:
            begin
                if (pos >= $size(BUNDLE_TAG) || b != BUNDLE_TAG[pos % $size(BUNDLE_TAG)])
                    hdr_ok = 1'b0;
                if (b == 8'h00)
                begin
                    field_end = (pos | (PAD_ALIGN - 1)) + 1;
                    if (nxt == field_end)
                        close_pad(nxt);
                    else
                        cur_phase = PH_PAD;
                end
            end
            PH_PAD:
            begin
                if (b != 8'h00)
                begin
                    first_err = STATUS_SIZE;
                    cur_phase = PH_DRAIN;
                end
                else if (nxt == field_end)
                    close_pad(nxt);
            end
            PH_TAG:
            begin
                if (nxt == field_end)
                    open_length(nxt);
            end
            PH_LEN:
            begin
                len_acc = (len_acc << 8) | b;
                if (nxt == field_end)
                begin
                    body_left = len_acc;
                    if (body_left == 0)
                        open_length(nxt);
                    else
                        cur_phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                body_left--;
                if (body_left == 0)
                    open_length(nxt);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic last);
        verdict_t v;
        // Past the size limit the length overrides whatever was found earlier.
        if (seen_bytes >= MAX_BYTES)
        begin
            first_err = STATUS_SIZE;
            cur_phase = PH_DRAIN;
        end
        else
        begin
            track_byte(b, seen_bytes);
            seen_bytes++;
        end
        if (last)
        begin
            v.total_length = '0;
            if (first_err != STATUS_OK)
                v.status = first_err;
            else if (cur_phase == PH_LEN && field_end == seen_bytes + LEN_BYTES)
            begin
                v.status       = STATUS_OK;
                v.total_length = 17'(seen_bytes);
            end
            else
                v.status = STATUS_SIZE;
            verdict_q.push_back(v);
            clear_tracking();
        end
    endtask

    initial
    begin
        clear_tracking();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_beat(data_byte, last_byte);
                beats_seen++;
            end
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch($sformatf("verdict status %0d length %0d with none expected",
                                              status, total_length));
                else
                begin
                    want = verdict_q.pop_front();
                    verdicts_seen++;
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (total_length !== want.total_length)
                        report_mismatch($sformatf("total_length %0d, expected %0d",
                                                  total_length, want.total_length));
                end
            end
        end
        mismatches <= fail_cnt;
        pending    <= verdict_q.size();
        verdicts   <= verdicts_seen;
        beats      <= beats_seen;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives byte buffers into the bundle validator: directed headers, pads,
// time tags and element boundaries first, then random bundles and broken
// buffers under four mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------

module tb;
    import obv_pkg::*;

    localparam int MAX_BYTES   = 65536;
    localparam int PAD_ALIGN   = 4;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_BYTES = 80;
    localparam int PHASE_BUFS  = 3;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [16:0] total_length;

    int          mismatches;
    int          pending;
    int          verdicts;
    int          beats;

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          quiet_cycles = 0;
    int          buffers_sent = 0;
    int          bytes_sent = 0;
    logic [7:0]  frame[$];

    osc_bundle_validator_core #(
        .MAX_BYTES(MAX_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .total_length(total_length)
    );

    osc_bundle_validator_checker #(
        .MAX_BYTES(MAX_BYTES)
    ) verdict_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .total_length(total_length),
        .mismatches(mismatches),
        .pending(pending),
        .verdicts(verdicts),
        .beats(beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic put_header();
        for (int k = 0; k < $size(BUNDLE_TAG); k++)
            frame.push_back(BUNDLE_TAG[k]);
    endtask

    task automatic put_noise(input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            frame.push_back(8'($urandom));
    endtask

    task automatic put_word(input logic [31:0] w);
        frame.push_back(w[31:24]);
        frame.push_back(w[23:16]);
        frame.push_back(w[15:8]);
        frame.push_back(w[7:0]);
    endtask

    task automatic put_elem(input int unsigned len);
        put_word(len);
        put_noise(len);
    endtask

    // Each beat is held until accepted; valid only drops during an idle gap.
    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid  <= 1'b1;
            data_byte <= frame[i];
            last_byte <= (i == frame.size() - 1);
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
        bytes_sent += frame.size();
        buffers_sent++;
        frame.delete();
    endtask

    task automatic make_random_frame();
        int kind;
        int n;
        int mut;
        int cut;
        int r;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            put_header();
            put_noise(TAG_BYTES);
            n = $urandom_range(0, 4);
            for (int e = 0; e < n; e++)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    put_word($urandom);
                else if (r < 4)
                    put_elem($urandom_range(13, 40));
                else
                    put_elem($urandom_range(0, 12));
            end
            mut = $urandom_range(0, 99);
            if (mut < 15)
            begin
                cut = $urandom_range(1, frame.size());
                while (frame.size() > cut)
                    void'(frame.pop_back());
            end
            else if (mut < 25)
                frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
            else if (mut < 30)
                put_noise($urandom_range(1, 3));
        end
        else if (kind < 85)
        begin
            // Near misses of the header string, then a mostly clean pad.
            n = $urandom_range(0, 11);
            for (int k = 0; k < n; k++)
            begin
                if (k < $size(BUNDLE_TAG) - 1 && $urandom_range(0, 1) == 1)
                    frame.push_back(BUNDLE_TAG[k]);
                else
                    frame.push_back(8'($urandom_range(1, 255)));
            end
            frame.push_back(8'h00);
            while (frame.size() % PAD_ALIGN != 0)
                frame.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                            : 8'h00);
            put_noise($urandom_range(0, 16));
        end
        else
        begin
            n = $urandom_range(1, 30);
            for (int k = 0; k < n; k++)
                frame.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
        end
    endtask

    initial
    begin
        int start_bytes;
        int start_bufs;
        int mix_idle[4];
        int mix_stall[4];

        mix_idle  = '{0, 80, 0, 26};
        mix_stall = '{0, 0, 80, 26};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest well-formed bundle: header and time tag only.
        put_header(); put_noise(TAG_BYTES); send_frame();
        put_header(); put_noise(TAG_BYTES); put_elem(0); send_frame();
        put_header(); put_noise(TAG_BYTES);
        put_elem(1); put_elem(2); put_elem(3); put_elem(5); put_elem(0);
        send_frame();
        put_header(); put_word(0); put_word(32'hFFFF_FFFF);
        put_word(4); put_word(32'h00FF_00FF);
        send_frame();

        // String with no terminator.
        for (int k = 0; k < $size(BUNDLE_TAG) - 1; k++)
            frame.push_back(BUNDLE_TAG[k]);
        send_frame();
        frame.push_back(8'hFF); send_frame();
        frame.push_back(8'h00); send_frame();

        // Nonzero byte inside the string pad.
        for (int k = 0; k < 4; k++)
            frame.push_back(BUNDLE_TAG[k]);
        frame.push_back(8'h00); frame.push_back(8'h00);
        frame.push_back(8'h01); frame.push_back(8'h00);
        put_noise(TAG_BYTES);
        send_frame();

        // Buffer ends inside the pad.
        frame.push_back(BUNDLE_TAG[0]); frame.push_back(BUNDLE_TAG[1]);
        frame.push_back(8'h00);
        send_frame();

        // Well-formed strings other than the bundle tag.
        for (int k = 0; k < $size(BUNDLE_TAG) - 2; k++)
            frame.push_back(BUNDLE_TAG[k]);
        frame.push_back(8'h78); frame.push_back(8'h00);
        put_noise(TAG_BYTES); put_elem(2);
        send_frame();
        put_word(0); put_noise(TAG_BYTES); send_frame();
        for (int k = 0; k < $size(BUNDLE_TAG) - 1; k++)
            frame.push_back(BUNDLE_TAG[k]);
        frame.push_back(8'h73); put_word(0); put_noise(TAG_BYTES);
        send_frame();

        // Time tag cut short, and no time tag at all.
        put_header(); put_noise(5); send_frame();
        put_header(); send_frame();

        // Ends inside an element length, inside a body, and with a huge length.
        put_header(); put_noise(TAG_BYTES); put_noise(2); send_frame();
        put_header(); put_noise(TAG_BYTES); put_word(10); put_noise(5); send_frame();
        put_header(); put_noise(TAG_BYTES); put_word(32'hFFFF_FFFF); put_noise(3);
        send_frame();

        // The first error sticks, whatever follows it.
        for (int k = 0; k < 4; k++)
            frame.push_back(BUNDLE_TAG[k]);
        frame.push_back(8'h00); frame.push_back(8'h80);
        put_header(); put_noise(TAG_BYTES);
        send_frame();
        put_word(0); put_header(); put_noise(40); send_frame();

        // One stray byte after a complete element.
        put_header(); put_noise(TAG_BYTES); put_elem(3); put_noise(1); send_frame();

        for (int m = 0; m < 4; m++)
        begin
            idle_pct    = mix_idle[m];
            stall_pct   = mix_stall[m];
            start_bytes = bytes_sent;
            start_bufs  = buffers_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES ||
                   buffers_sent - start_bufs < PHASE_BUFS)
            begin
                make_random_frame();
                send_frame();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Sent %0d buffers (%0d bytes, %0d taken in): directed header, pad, tag",
                 buffers_sent, bytes_sent, beats);
        $display("and element cases, then random traffic under four idle/stall mixes;");
        $display("%0d verdicts compared.", verdicts);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/obv_pkg.sv
sv/osc_bundle_validator_core.sv
tb/osc_bundle_validator_checker.sv
tb/tb.sv
